### hdl/coordinate_keyed_sparse_store_defines.svh
// Assertion macros for the checker file of the sparse store.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef COORDINATE_KEYED_SPARSE_STORE_DEFINES_SVH
`define COORDINATE_KEYED_SPARSE_STORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CKS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CKS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cks_pkg.sv
// Shared types and constants of the coordinate-keyed sparse store.
// No dependencies.
package cks_pkg;

    localparam int KEY_W     = 24;
    localparam int VAL_W     = 64;
    localparam int COUNT_W   = 9;
    localparam int ENTRY_W   = 2 * KEY_W + VAL_W;

    // Operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    // Status codes
    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE
    } state_t;

endpackage

### hdl/cks_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/coordinate_keyed_sparse_store.sv
// Coordinate-list sparse store keyed by (row, column); uses cks_pkg and cks_ram.
// One item at a time: a request is accepted only in idle, then the key scan steps the
// single RAM read port one entry per cycle, stopping at a hit or at the fill count;
// the result then waits in resolve until the output register is free, so a stalled
// result holds off the next request.
// Reset clears the fill count and control; RAM contents are not cleared.
module coordinate_keyed_sparse_store
    import cks_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_ready,
    input  logic               opcode,
    input  logic [KEY_W-1:0]   row_index,
    input  logic [KEY_W-1:0]   column_index,
    input  logic [VAL_W-1:0]   write_value,
    // response channel
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [VAL_W-1:0]   read_value,
    output logic               found,
    output logic               status,
    output logic [COUNT_W-1:0] entry_count
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

    // Control registers
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Payload registers
    logic              op_reg, op_next;
    logic [KEY_W-1:0]  row_reg, row_next;
    logic [KEY_W-1:0]  col_reg, col_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              hit_reg, hit_next;
    logic [VAL_W-1:0]  rdval_reg, rdval_next;
    logic [VAL_W-1:0]  out_value_reg, out_value_next;
    logic              out_found_reg, out_found_next;
    logic              out_status_reg, out_status_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    // RAM port signals
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic                 scan_more;
    logic                 key_hit;
    logic                 rsp_free;
    logic                 do_append;
    logic [CNT_W+COUNT_W-1:0] count_wide;

    cks_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES),
        .ADDR_W(IDX_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Scan status
    assign scan_more = (scan_reg < fill_reg);
    assign key_hit   = pend_reg
                       && (ram_rdata[ENTRY_W-1 -: KEY_W] == row_reg)
                       && (ram_rdata[VAL_W +: KEY_W] == col_reg);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign do_append = (op_reg == OP_SET) && !hit_reg && (fill_reg < FULL_COUNT);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (key_hit || (!pend_reg && !scan_more))
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        fill_next       = fill_reg;
        scan_next       = scan_reg;
        pend_next       = 1'b0;
        op_next         = op_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        val_next        = val_reg;
        cmp_idx_next    = cmp_idx_reg;
        slot_next       = slot_reg;
        hit_next        = hit_reg;
        rdval_next      = rdval_reg;
        out_value_next  = out_value_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        ram_we          = 1'b0;
        ram_waddr       = slot_reg;
        ram_wdata       = {row_reg, col_reg, val_reg};
        ram_re          = 1'b0;
        ram_raddr       = scan_reg[IDX_W-1:0];
        count_wide      = {{COUNT_W{1'b0}}, fill_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next   = opcode;
                    row_next  = row_index;
                    col_next  = column_index;
                    val_next  = write_value;
                    scan_next = '0;
                    hit_next  = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle; compare the one issued last cycle
                if (scan_more && !key_hit)
                begin
                    ram_re       = 1'b1;
                    scan_next    = scan_reg + 1'b1;
                    pend_next    = 1'b1;
                    cmp_idx_next = scan_reg[IDX_W-1:0];
                end
                if (key_hit)
                begin
                    hit_next   = 1'b1;
                    slot_next  = cmp_idx_reg;
                    rdval_next = ram_rdata[VAL_W-1:0];
                end
            end
            ST_RESOLVE:
            begin
                // commit the update and load the output register
                if (rsp_free)
                begin
                    if ((op_reg == OP_SET) && hit_reg)
                    begin
                        ram_we = 1'b1;
                    end
                    else if (do_append)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = fill_reg[IDX_W-1:0];
                        fill_next = fill_reg + 1'b1;
                    end
                    count_wide      = {{COUNT_W{1'b0}}, fill_next};
                    out_value_next  = ((op_reg == OP_GET) && hit_reg) ? rdval_reg : '0;
                    out_found_next  = hit_reg;
                    out_status_next = ((op_reg == OP_SET) && !hit_reg && !do_append)
                                      ? STAT_FULL : STAT_DONE;
                    out_count_next  = count_wide[COUNT_W-1:0];
                    rsp_valid_next  = 1'b1;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        val_reg        <= val_next;
        cmp_idx_reg    <= cmp_idx_next;
        slot_reg       <= slot_next;
        hit_reg        <= hit_next;
        rdval_reg      <= rdval_next;
        out_value_reg  <= out_value_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign req_ready   = (state_reg == ST_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign read_value  = out_value_reg;
    assign found       = out_found_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;

endmodule

### hdl/cks_checker.sv
// Port-level assertions for the sparse store, bound to the top level.
// Depends on cks_pkg and coordinate_keyed_sparse_store_defines.svh.
`include "coordinate_keyed_sparse_store_defines.svh"

module cks_checker
    import cks_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [VAL_W-1:0]   read_value,
    input logic               found,
    input logic               status,
    input logic [COUNT_W-1:0] entry_count
);

    logic                             rsp_full;
    logic                             full_ok;
    logic [VAL_W+COUNT_W+1:0]         rsp_word;

    // Result fields gathered for the checks below
    assign rsp_full = rsp_valid && (status == STAT_FULL);
    assign full_ok  = !found && (read_value == '0) && (entry_count == COUNT_W'(ENTRIES));
    assign rsp_word = {read_value, found, status, entry_count};

    // A dropped set never reports a hit or a value, and the store is full
    `CKS_ASSERT_NOW(a_full_consistent, rsp_full, full_ok, "full status with hit or count")

    // A nonzero value only comes from a hit
    `CKS_ASSERT_NOW(a_value_needs_hit, rsp_valid && (read_value != '0), found, "value without hit")

    // An accepted item leaves the store busy: ready drops in the cycle after the accept
    `CKS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")

    // A stalled result holds
    `CKS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "result moved")

endmodule

bind coordinate_keyed_sparse_store cks_checker #(.ENTRIES(ENTRIES)) u_cks_checker (.*);

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for coordinate_keyed_sparse_store: a directed table, then random
// get/set traffic that fills the store to capacity and keeps working it once full.
// Depends on cks_pkg and the store RTL only.
module tb
    import cks_pkg::*;
();

    localparam int DEPTH       = 256;
    localparam int FULL_ITEMS  = 600;      // random items issued once the store is full
    localparam int HOLD_AT     = 300;      // result index where the receiver holds off
    localparam int HOLD_CYCLES = 600;
    localparam int MAX_REPORTS = 10;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [KEY_W-1:0] KEY_MAX  = '1;
    localparam logic [VAL_W-1:0] VAL_ONES = '1;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] row;
        logic [KEY_W-1:0] col;
        logic [VAL_W-1:0] val;
    } request_t;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic               hit;
        logic               stat;
        logic [COUNT_W-1:0] count;
    } answer_t;

    typedef struct packed {
        request_t rq;
        logic     typed;
        answer_t  ans;
    } table_row_t;

    // DUT signals
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               req_valid    = 1'b0;
    logic               req_ready;
    logic               opcode       = OP_GET;
    logic [KEY_W-1:0]   row_index    = '0;
    logic [KEY_W-1:0]   column_index = '0;
    logic [VAL_W-1:0]   write_value  = '0;
    logic               rsp_valid;
    logic               rsp_ready    = 1'b0;
    logic [VAL_W-1:0]   read_value;
    logic               found;
    logic               status;
    logic [COUNT_W-1:0] entry_count;

    // Shadow copy of the store contents
    logic [KEY_W-1:0]   shadow_row [DEPTH];
    logic [KEY_W-1:0]   shadow_col [DEPTH];
    logic [VAL_W-1:0]   shadow_val [DEPTH];
    int                 shadow_fill = 0;

    answer_t            expected_answers [$];
    table_row_t         directed_rows [$];

    int  sent_count     = 0;
    int  answered_count = 0;
    int  error_count    = 0;
    int  get_count      = 0;
    int  set_count      = 0;
    int  hit_count      = 0;
    int  drop_count     = 0;
    int  cycle_count    = 0;
    bit  tx_quiet       = 1'b0;

    coordinate_keyed_sparse_store #(.ENTRIES(DEPTH)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .opcode       (opcode),
        .row_index    (row_index),
        .column_index (column_index),
        .write_value  (write_value),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .read_value   (read_value),
        .found        (found),
        .status       (status),
        .entry_count  (entry_count)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_answers.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Apply one request to the shadow store and return the answer it produces
    function automatic answer_t store_apply(input request_t rq);
        answer_t a;
        int      slot;
        int      k;
        slot = -1;
        for (k = 0; k < shadow_fill; k++)
        begin
            if (slot < 0 && shadow_row[k] == rq.row && shadow_col[k] == rq.col)
                slot = k;
        end
        a      = '0;
        a.hit  = (slot >= 0);
        a.stat = STAT_DONE;
        if (a.hit)
            hit_count++;
        if (rq.op == OP_GET)
        begin
            get_count++;
            if (a.hit)
                a.value = shadow_val[slot];
        end
        else
        begin
            set_count++;
            if (a.hit)
                shadow_val[slot] = rq.val;
            else if (shadow_fill < DEPTH)
            begin
                shadow_row[shadow_fill] = rq.row;
                shadow_col[shadow_fill] = rq.col;
                shadow_val[shadow_fill] = rq.val;
                shadow_fill++;
            end
            else
            begin
                // full store, new key: dropped
                a.stat = STAT_FULL;
                drop_count++;
            end
        end
        a.count = COUNT_W'(shadow_fill);
        return a;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return KEY_MAX;
            default: return KEY_W'($urandom());
        endcase
    endfunction

    // Keys: a stored key (60 percent; 25 for a set while not full), 10 percent one bit off a stored key, the rest fresh
    function automatic request_t random_request();
        request_t rq;
        int       pick;
        int       hit_pct;
        int       slot;
        int       b;
        rq.op   = ($urandom_range(0, 9) < 6) ? OP_SET : OP_GET;
        hit_pct = (rq.op == OP_SET && shadow_fill < DEPTH) ? 25 : 60;
        pick    = $urandom_range(0, 99);
        slot    = (shadow_fill > 0) ? $urandom_range(0, shadow_fill - 1) : 0;
        b       = $urandom_range(0, KEY_W - 1);
        if (shadow_fill > 0 && pick < hit_pct + 10)
        begin
            rq.row = shadow_row[slot];
            rq.col = shadow_col[slot];
            if (pick >= hit_pct)
            begin
                if ($urandom_range(0, 1) == 1)
                    rq.row[b] = ~rq.row[b];
                else
                    rq.col[b] = ~rq.col[b];
            end
        end
        else
        begin
            rq.row = random_key();
            rq.col = random_key();
        end
        case ($urandom_range(0, 7))
            0:       rq.val = '0;
            1:       rq.val = VAL_ONES;
            default: rq.val = {$urandom(), $urandom()};
        endcase
        return rq;
    endfunction

    function automatic void add_row(input logic op, input logic [KEY_W-1:0] row,
                                    input logic [KEY_W-1:0] col, input logic [VAL_W-1:0] val,
                                    input logic typed, input logic [VAL_W-1:0] value,
                                    input logic hit, input logic stat,
                                    input logic [COUNT_W-1:0] count);
        table_row_t t;
        t.rq    = {op, row, col, val};
        t.typed = typed;
        t.ans   = {value, hit, stat, count};
        directed_rows.push_back(t);
    endfunction

    // Drive one item at the falling edge and hold it until accepted
    task automatic send_request(input request_t rq, input logic typed,
                                input answer_t typed_ans);
        int      gap;
        answer_t predicted;
        if (sent_count % 50 == 0)
            tx_quiet = ($urandom_range(0, 2) == 0);
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid    <= 1'b1;
        opcode       <= rq.op;
        row_index    <= rq.row;
        column_index <= rq.col;
        write_value  <= rq.val;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        predicted = store_apply(rq);
        expected_answers.push_back(typed ? typed_ans : predicted);
        sent_count++;
    endtask

    task automatic report_mismatch(input string what, input answer_t want,
                                   input answer_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t %s (value/found/status/count): exp %h/%b/%b/%0d got %h/%b/%b/%0d",
                     $realtime, what, want.value, want.hit, want.stat, want.count,
                     got.value, got.hit, got.stat, got.count);
    endtask

    // Response side: random ready gaps, one long hold-off, in-order checking
    initial
    begin : answer_checker
        int      gap;
        bit      rx_quiet;
        answer_t want;
        answer_t got;
        rx_quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (answered_count % 50 == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
            gap = rx_quiet ? 0 : $urandom_range(0, 11);
            if (answered_count == HOLD_AT)
                gap = HOLD_CYCLES;
            repeat (gap)
            begin
                @(negedge clk);
                rsp_ready <= 1'b0;
            end
            @(negedge clk);
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            got = {read_value, found, status, entry_count};
            answered_count++;
            if (expected_answers.size() == 0)
                report_mismatch("unexpected result", '0, got);
            else
            begin
                want = expected_answers.pop_front();
                if (got.value !== want.value || got.hit !== want.hit ||
                    got.stat !== want.stat || got.count !== want.count)
                    report_mismatch("mismatch", want, got);
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        answer_t none;
        none = '0;

        // op, row, col, write value, typed, value, found, status, count
        add_row(OP_GET, 24'h000000, 24'h000000, 64'h0, 1'b1, 64'h0, 1'b0, STAT_DONE, 9'd0);
        add_row(OP_SET, 24'h000000, 24'h000000, VAL_ONES, 1'b1, 64'h0, 1'b0, STAT_DONE, 9'd1);
        add_row(OP_GET, 24'h000000, 24'h000000, 64'h0, 1'b1, VAL_ONES, 1'b1, STAT_DONE, 9'd1);
        add_row(OP_SET, KEY_MAX, KEY_MAX, 64'h0, 1'b1, 64'h0, 1'b0, STAT_DONE, 9'd2);
        // write value must be ignored on a get
        add_row(OP_GET, KEY_MAX, KEY_MAX, VAL_ONES, 1'b1, 64'h0, 1'b1, STAT_DONE, 9'd2);
        // row or column alone matching is a miss
        add_row(OP_GET, 24'h000000, KEY_MAX, 64'h0, 1'b1, 64'h0, 1'b0, STAT_DONE, 9'd2);
        add_row(OP_GET, KEY_MAX, 24'h000000, 64'h0, 1'b1, 64'h0, 1'b0, STAT_DONE, 9'd2);
        add_row(OP_SET, 24'h000000, KEY_MAX, 64'h8000_0000_0000_0000, 1'b1,
                64'h0, 1'b0, STAT_DONE, 9'd3);
        add_row(OP_SET, KEY_MAX, 24'h000000, 64'h1, 1'b1, 64'h0, 1'b0, STAT_DONE, 9'd4);
        // overwrite of an existing key keeps the count
        add_row(OP_SET, 24'h000000, 24'h000000, 64'h3FF0_0000_0000_0000, 1'b1,
                64'h0, 1'b1, STAT_DONE, 9'd4);
        add_row(OP_GET, 24'h000000, 24'h000000, VAL_ONES, 1'b1,
                64'h3FF0_0000_0000_0000, 1'b1, STAT_DONE, 9'd4);
        add_row(OP_GET, 24'h000000, KEY_MAX, VAL_ONES, 1'b1,
                64'h8000_0000_0000_0000, 1'b1, STAT_DONE, 9'd4);
        add_row(OP_GET, KEY_MAX, 24'h000000, 64'h0, 1'b1, 64'h1, 1'b1, STAT_DONE, 9'd4);
        add_row(OP_SET, 24'h123456, 24'hABCDEF, 64'h5555_5555_5555_5555, 1'b0,
                64'h0, 1'b0, STAT_DONE, 9'd0);
        add_row(OP_SET, 24'hABCDEF, 24'h123456, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0,
                64'h0, 1'b0, STAT_DONE, 9'd0);
        add_row(OP_GET, 24'h123456, 24'hABCDEF, 64'h0, 1'b0, 64'h0, 1'b0, STAT_DONE, 9'd0);
        add_row(OP_GET, 24'hABCDEF, 24'h123456, 64'h0, 1'b0, 64'h0, 1'b0, STAT_DONE, 9'd0);
        add_row(OP_SET, KEY_MAX, KEY_MAX, 64'h7FF8_0000_0000_0001, 1'b1,
                64'h0, 1'b1, STAT_DONE, 9'd6);
        add_row(OP_GET, KEY_MAX, KEY_MAX, 64'h0, 1'b1,
                64'h7FF8_0000_0000_0001, 1'b1, STAT_DONE, 9'd6);
        add_row(OP_GET, 24'h000001, 24'h000000, 64'h0, 1'b1, 64'h0, 1'b0, STAT_DONE, 9'd6);
        add_row(OP_SET, 24'h800000, 24'h000001, 64'hFFF0_0000_0000_0000, 1'b0,
                64'h0, 1'b0, STAT_DONE, 9'd0);
        add_row(OP_GET, 24'h800000, 24'h000001, 64'h0, 1'b0, 64'h0, 1'b0, STAT_DONE, 9'd0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].ans);

        // fill to capacity, then keep going with the store full
        while (shadow_fill < DEPTH)
            send_request(random_request(), 1'b0, none);
        repeat (FULL_ITEMS)
            send_request(random_request(), 1'b0, none);
        @(negedge clk);
        req_valid <= 1'b0;

        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 16) @(posedge clk);

        $display("Ran %0d requests (%0d gets, %0d sets): %0d key hits, %0d sets refused when full",
                 sent_count, get_count, set_count, hit_count, drop_count);
        $display("Checked %0d results, %0d mismatches", answered_count, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/cks_pkg.sv
hdl/cks_ram.sv
hdl/coordinate_keyed_sparse_store.sv
hdl/cks_checker.sv
dv/tb.sv
